// File: hw/rtl/mmca_pkg.sv
// Shared constants, types and state encoding for the masked mean amplitude block.
`timescale 1ns / 1ps
`default_nettype none
package mmca_pkg;

  localparam int DEF_FRAC_BITS   = 8;
  localparam int DEF_COUNT_WIDTH = 32;

  localparam int COMP_W    = 16;  // raw component width
  localparam int MAG2_W    = 32;  // exact squared magnitude
  localparam int THR_W     = 32;
  localparam int SUM_W     = 56;  // amplitude accumulator
  localparam int MEAN_W    = 24;  // mean amplitude field
  localparam int OUT_CNT_W = 32;  // count fields of the result
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 88;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_BYTE_SWAP   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MASK_ENABLE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_AMP2_THRESH = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_RE,
    S_SQ_IM,
    S_CMP,
    S_ROOT,
    S_DIVGO,
    S_DIV,
    S_OUT
  } mmca_state_t;

  // Status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } mmca_unit_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/masked_mean_complex_amplitude.sv
// Masked mean amplitude of complex pixels: sequencer, accumulators and output register.
//
// Usage:
//   in_*  : one complex pixel per transaction. in_tdata = {imag_raw, real_raw},
//           in_tuser = masked, in_tlast marks the final pixel of an image.
//   out_* : one result per image, sent after the pixel with in_tlast.
//   cfg_* : register writes (byte_swap, mask_enable, mag2 threshold), only while idle.
// Flow: one pixel at a time. A masked or at-or-below-threshold pixel passes through
//   S_SQ_RE, S_SQ_IM and S_CMP; a counted pixel then waits in S_ROOT for the
//   bit-per-cycle square root, which yields one root bit per cycle.
// The last pixel adds a mean stage: S_DIVGO, the 24-step restoring divider in S_DIV
//   when at least one pixel counted and the mean does not saturate, and S_OUT.
// The result sits in an output register; in_tready returns as soon as the result is
//   loaded, so the next image proceeds while the receiver stalls. A further last pixel
//   waits until the previous result has been taken.
// Reset (rst_n low, synchronous) clears the state, config, sums and counts, and drops
//   any pending result.
`timescale 1ns / 1ps
`default_nettype none
module masked_mean_complex_amplitude #(
  parameter int FRAC_BITS   = mmca_pkg::DEF_FRAC_BITS,
  parameter int COUNT_WIDTH = mmca_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // fields from bit 0: real_raw[15:0], imag_raw[31:16]
  input  wire logic [mmca_pkg::IN_DATA_W-1:0]    in_tdata,
  // fields from bit 0: masked
  input  wire logic                              in_tuser,
  input  wire logic                              in_tlast,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // fields from bit 0: mean_amplitude[23:0], nonzero_count[55:24], zero_count[87:56]
  output logic [mmca_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_we,
  input  wire logic [mmca_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [mmca_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int RW    = mmca_pkg::COMP_W + FRAC_BITS;  // root width
  localparam int HI_W  = mmca_pkg::SUM_W - mmca_pkg::MEAN_W;
  localparam int CMP_W = (HI_W > COUNT_WIDTH) ? HI_W : COUNT_WIDTH;
  localparam int OCW   = mmca_pkg::OUT_CNT_W;

  mmca_pkg::mmca_state_t state_r, state_nxt;

  // configuration
  logic                          byte_swap_r;
  logic                          mask_enable_r;
  logic [mmca_pkg::THR_W-1:0]    thr_r;

  // pixel holding registers
  logic signed [mmca_pkg::COMP_W-1:0] re_r, im_r;
  logic                               skip_r;
  logic                               last_r;
  logic [mmca_pkg::MAG2_W-1:0]        mag2_r;

  // accumulators
  logic [mmca_pkg::SUM_W-1:0] sum_r;
  logic [COUNT_WIDTH-1:0]     pcount_r;
  logic [COUNT_WIDTH-1:0]     ecount_r;

  logic [mmca_pkg::MEAN_W-1:0]     mean_r;
  logic [mmca_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                            out_valid_r;

  // sequencer outputs
  logic mul_im;
  logic sqrt_start;
  logic div_start;
  logic bump_empty;
  logic acc_en;
  logic load_out;

  logic [mmca_pkg::COMP_W-1:0] re_sw, im_sw;
  logic signed [mmca_pkg::COMP_W-1:0]   mul_op;
  logic signed [2*mmca_pkg::COMP_W-1:0] prod;
  logic        count_empty;
  logic        pcount_full;
  logic        mean_sat;
  logic        out_free;
  logic [RW-1:0]                   amp;
  logic [mmca_pkg::SUM_W:0]        sum_add;
  logic [mmca_pkg::MEAN_W-1:0]     quot;
  logic [OCW-1:0]                  nz_out, z_out;
  mmca_pkg::mmca_unit_sts_t        sqrt_sts, div_sts;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_swap_r   <= 1'b0;
      mask_enable_r <= 1'b0;
      thr_r         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mmca_pkg::CFG_BYTE_SWAP:   byte_swap_r   <= cfg_wdata[0];
        mmca_pkg::CFG_MASK_ENABLE: mask_enable_r <= cfg_wdata[0];
        mmca_pkg::CFG_AMP2_THRESH: thr_r         <= cfg_wdata[mmca_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  assign re_sw = byte_swap_r ? {in_tdata[7:0], in_tdata[15:8]} : in_tdata[15:0];
  assign im_sw = byte_swap_r ? {in_tdata[23:16], in_tdata[31:24]} : in_tdata[31:16];

  // one squarer, shared between the two components
  assign mul_op = mul_im ? im_r : re_r;
  assign prod   = mul_op * mul_op;

  assign count_empty = skip_r || (mag2_r <= thr_r);
  assign pcount_full = &pcount_r;
  assign mean_sat    = CMP_W'(sum_r[mmca_pkg::SUM_W-1:mmca_pkg::MEAN_W]) >=
                       CMP_W'(pcount_r);
  assign out_free    = !out_valid_r || out_tready;
  assign sum_add     = {1'b0, sum_r} + (mmca_pkg::SUM_W + 1)'(amp);

  generate
    if (COUNT_WIDTH > OCW) begin : g_cnt_sat
      assign nz_out = (|pcount_r[COUNT_WIDTH-1:OCW]) ? '1 : pcount_r[OCW-1:0];
      assign z_out  = (|ecount_r[COUNT_WIDTH-1:OCW]) ? '1 : ecount_r[OCW-1:0];
    end else begin : g_cnt_ext
      assign nz_out = OCW'(pcount_r);
      assign z_out  = OCW'(ecount_r);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      re_r   <= re_sw;
      im_r   <= im_sw;
      skip_r <= mask_enable_r && in_tuser;
      last_r <= in_tlast;
    end
    if (state_r == mmca_pkg::S_SQ_RE) begin
      mag2_r <= $unsigned(prod);
    end else if (state_r == mmca_pkg::S_SQ_IM) begin
      mag2_r <= mag2_r + $unsigned(prod);
    end
    if (state_r == mmca_pkg::S_DIVGO) begin
      mean_r <= (pcount_r == '0) ? '0 : '1;
    end else if (div_sts.done) begin
      mean_r <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      pcount_r <= '0;
      ecount_r <= '0;
    end else if (load_out) begin
      sum_r    <= '0;
      pcount_r <= '0;
      ecount_r <= '0;
    end else begin
      if (bump_empty && !(&ecount_r)) begin
        ecount_r <= ecount_r + 1'b1;
      end
      if (acc_en) begin
        sum_r    <= sum_add[mmca_pkg::SUM_W] ? '1 : sum_add[mmca_pkg::SUM_W-1:0];
        pcount_r <= pcount_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {z_out, nz_out, mean_r};
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // ---------------------------------------------------------------- units
  mmca_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     ({mag2_r, {(RW - mmca_pkg::MAG2_W / 2) * 2{1'b0}}}),
    .root  (amp),
    .sts   (sqrt_sts)
  );

  mmca_div #(
    .NW (COUNT_WIDTH),
    .QW (mmca_pkg::MEAN_W),
    .DW (mmca_pkg::SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (pcount_r),
    .quot     (quot),
    .sts      (div_sts)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmca_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mmca_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = mmca_pkg::S_SQ_RE;
      end
      mmca_pkg::S_SQ_RE: state_nxt = mmca_pkg::S_SQ_IM;
      mmca_pkg::S_SQ_IM: state_nxt = mmca_pkg::S_CMP;
      mmca_pkg::S_CMP: begin
        if (count_empty || pcount_full) begin
          state_nxt = last_r ? mmca_pkg::S_DIVGO : mmca_pkg::S_IDLE;
        end else begin
          state_nxt = mmca_pkg::S_ROOT;
        end
      end
      mmca_pkg::S_ROOT: begin
        if (sqrt_sts.done) state_nxt = last_r ? mmca_pkg::S_DIVGO : mmca_pkg::S_IDLE;
      end
      mmca_pkg::S_DIVGO: begin
        // no counted pixel or an oversized mean skips the divider
        if (pcount_r == '0 || mean_sat) begin
          state_nxt = mmca_pkg::S_OUT;
        end else begin
          state_nxt = mmca_pkg::S_DIV;
        end
      end
      mmca_pkg::S_DIV: begin
        if (div_sts.done) state_nxt = mmca_pkg::S_OUT;
      end
      mmca_pkg::S_OUT: begin
        if (out_free) state_nxt = mmca_pkg::S_IDLE;
      end
      default: state_nxt = mmca_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    mul_im     = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    bump_empty = 1'b0;
    acc_en     = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      mmca_pkg::S_IDLE:  in_tready = 1'b1;
      mmca_pkg::S_SQ_RE: mul_im = 1'b0;
      mmca_pkg::S_SQ_IM: mul_im = 1'b1;
      mmca_pkg::S_CMP: begin
        bump_empty = count_empty;
        sqrt_start = !count_empty && !pcount_full;
      end
      mmca_pkg::S_ROOT:  acc_en = sqrt_sts.done;
      mmca_pkg::S_DIVGO: div_start = (pcount_r != '0) && !mean_sat;
      mmca_pkg::S_DIV:   ;
      mmca_pkg::S_OUT:   load_out = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- checks
  a_sqrt_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> !sqrt_sts.busy)
    else $error("square root restarted while busy");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == mmca_pkg::S_DIV)
    else $error("divider finished outside the mean stage");

  a_root_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_sts.done |-> state_r == mmca_pkg::S_ROOT)
    else $error("square root finished outside the root stage");

  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (pcount_r == '0) && (ecount_r == '0) && (sum_r == '0) && out_valid_r)
    else $error("accumulators not cleared after result load");

  a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_tready))
    else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

// File: hw/rtl/mmca_sqrt.sv
// Bit-per-cycle integer square root of a 2*RW-bit value, rounded down.
`timescale 1ns / 1ps
`default_nettype none
module mmca_sqrt #(
  parameter int RW = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [2*RW-1:0]        x,
  output logic      [RW-1:0]          root,
  output mmca_pkg::mmca_unit_sts_t    sts
);

  localparam int CW = $clog2(RW);

  logic [2*RW-1:0] x_r, x_nxt;
  logic [RW:0]     rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;

  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          ge;

  // Bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem_r[RW-1:0], x_r[2*RW-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = x;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CW'(RW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt    = {x_r[2*RW-3:0], 2'b00};
      rem_nxt  = ge ? diff[RW:0] : rem_sh[RW:0];
      root_nxt = {root_r[RW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign root     = root_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire

// File: hw/rtl/mmca_div.sv
// Restoring divider: QW quotient bits of a DW-bit dividend by an NW-bit divisor, one per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mmca_div #(
  parameter int NW = 32,
  parameter int QW = 24,
  parameter int DW = 56
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [DW-1:0]          dividend,
  input  wire logic [NW-1:0]          divisor,
  output logic      [QW-1:0]          quot,
  output mmca_pkg::mmca_unit_sts_t    sts
);

  localparam int CW = $clog2(QW);

  logic [NW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] lo_r, lo_nxt;
  logic [NW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [NW:0] t;
  logic [NW:0] diff;
  logic        ge;

  // The caller guarantees dividend / 2^QW < divisor, so the high part fits NW bits
  assign t    = {rem_r, lo_r[QW-1]};
  assign ge   = t >= {1'b0, d_r};
  assign diff = t - {1'b0, d_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = NW'(dividend >> QW);
      lo_nxt   = dividend[QW-1:0];
      d_nxt    = divisor;
      cnt_nxt  = CW'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[NW-1:0] : t[NW-1:0];
      lo_nxt  = {lo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot     = lo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire
